/* rtl/disk_image_sector_chain_loader_defines.svh */
// Assertion macros for the sector chain loader RTL.
`ifndef DISK_IMAGE_SECTOR_CHAIN_LOADER_DEFINES_SVH
`define DISK_IMAGE_SECTOR_CHAIN_LOADER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, idle while rst_ni is low
`define DSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, idle while rst_ni is low
`define DSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DSL_ASSERT_IMP(lbl, ante, cons, msg)
`define DSL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/dsl_pkg.sv */
// Types, codes and track tables for the sector chain loader.
`timescale 1ns / 1ps

package dsl_pkg;

  localparam int unsigned NUM_TRACKS = 35;
  localparam int unsigned MAX_BLOCKS = 4096;
  localparam int unsigned BLK_W      = 13;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned OFS_W      = 18;
  localparam int unsigned SECIDX_W   = 10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'b01,
    PH_RECV = 2'b10
  } phase_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_READ = 2'd1,
    EV_DONE = 2'd2,
    EV_ERR  = 2'd3
  } event_e;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_BYTE  = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_USE_FILE_ADDR = 1'b0,
    CFG_RELOC_ADDR    = 1'b1
  } cfg_idx_e;

  // Sectors on each track, track 0 unused
  localparam logic [4:0] SPT [36] = '{
    5'd0,
    5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
    5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
    5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
    5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18,
    5'd17, 5'd17, 5'd17, 5'd17, 5'd17
  };

  // Sectors on all tracks below each track
  localparam logic [SECIDX_W-1:0] CUM [36] = '{
    10'd0,
    10'd0,   10'd21,  10'd42,  10'd63,  10'd84,  10'd105, 10'd126, 10'd147, 10'd168,
    10'd189, 10'd210, 10'd231, 10'd252, 10'd273, 10'd294, 10'd315, 10'd336,
    10'd357, 10'd376, 10'd395, 10'd414, 10'd433, 10'd452, 10'd471,
    10'd490, 10'd508, 10'd526, 10'd544, 10'd562, 10'd580,
    10'd598, 10'd615, 10'd632, 10'd649, 10'd666
  };

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] trk;
    logic [7:0] sec;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [OFS_W-1:0]  offset;
  } map_t;

  typedef struct packed {
    logic              wr_valid;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    event_e            ev;
    logic [OFS_W-1:0]  read_offset;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] end_addr;
  } res_t;

endpackage

/* rtl/disk_image_sector_chain_loader.sv */
// Top level: input stage, chain core and result stage of the sector chain loader.
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid_i / in_ready_o   command, start track/sector, data byte
//   out      source     out_valid_o / out_ready_i write, event, offset, start/end address
//   cfg      sink       cfg_we_i                  register index, write data
//
// Every item gives one result, registered in the result stage as the item
// leaves the input stage. One item per cycle is taken while the result stage
// drains; the chain state steps with each item, so nothing else limits the rate.
// A stalled result holds the result stage; the input stage then fills and
// in_ready_o falls. Reset empties both stages and returns the chain to idle.
`timescale 1ns / 1ps

`include "disk_image_sector_chain_loader_defines.svh"

module disk_image_sector_chain_loader import dsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [7:0]        start_track_i,
  input  logic [7:0]        start_sector_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              write_valid_o,
  output logic [ADDR_W-1:0] write_address_o,
  output logic [7:0]        write_data_o,
  output logic [1:0]        event_res_o,
  output logic [OFS_W-1:0]  read_offset_o,
  output logic [ADDR_W-1:0] start_address_o,
  output logic [ADDR_W-1:0] end_address_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [ADDR_W-1:0] cfg_data_i
);

  logic     in_valid_q;
  in_item_t in_item_q;
  logic     out_valid_q;
  res_t     res_q;
  res_t     res;
  logic     advance;
  logic     in_take;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  dsl_chain_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_item_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_o       (res)
  );

  // Track occupancy of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture item and result payloads
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= '{cmd: cmd_e'(command_i), trk: start_track_i,
                     sec: start_sector_i, data: data_byte_i};
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign write_valid_o   = res_q.wr_valid;
  assign write_address_o = res_q.wr_addr;
  assign write_data_o    = res_q.wr_data;
  assign event_res_o     = res_q.ev;
  assign read_offset_o   = res_q.read_offset;
  assign start_address_o = res_q.start_addr;
  assign end_address_o   = res_q.end_addr;

  `DSL_ASSERT_IMP(a_done_end_follows_write, out_valid_q && res_q.wr_valid && (res_q.ev == EV_DONE), res_q.end_addr == (res_q.wr_addr + 16'd1), "end address does not follow last write")
  `DSL_ASSERT_IMP(a_read_sector_aligned, out_valid_q && (res_q.ev == EV_READ), (res_q.read_offset[7:0] == 8'h00) && (res_q.read_offset < 18'd174848), "read offset not a sector in the image")
  `DSL_ASSERT_IMP(a_addr_only_with_done, out_valid_q && (res_q.ev != EV_DONE), (res_q.start_addr == '0) && (res_q.end_addr == '0), "start or end address outside done")
  `DSL_ASSERT_NEXT(a_stall_keeps_item, in_valid_q && out_valid_q && !out_ready_i, in_valid_q && out_valid_q, "stalled input stage lost its item")

endmodule

/* rtl/dsl_sector_map.sv */
// Track and sector to image byte offset, with sector range check.
`timescale 1ns / 1ps

module dsl_sector_map import dsl_pkg::*; (
  input  logic [7:0] trk_i,
  input  logic [7:0] sec_i,
  output map_t       map_o
);

  logic                in_range;
  logic [5:0]          idx;
  logic [SECIDX_W-1:0] blk;

  assign in_range = (trk_i >= 8'd1) && (trk_i <= 8'(NUM_TRACKS));
  // Keep the table index on the disk for tracks that are not
  assign idx      = in_range ? trk_i[5:0] : 6'd0;

  // Count sectors ahead of this one and scale to bytes
  always_comb begin
    map_o = '0;
    blk   = CUM[idx] + SECIDX_W'(sec_i);
    if (in_range && (sec_i < {3'b000, SPT[idx]})) begin
      map_o.ok     = 1'b1;
      map_o.offset = {blk, 8'h00};
    end
  end

endmodule

/* rtl/dsl_chain_core.sv */
// Chain state, configuration registers and per-item step logic.
`timescale 1ns / 1ps

module dsl_chain_core import dsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  in_item_t          item_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [ADDR_W-1:0] cfg_data_i,
  output res_t              res_o
);

  phase_e            phase_q, phase_d;
  logic [7:0]        pos_q, pos_d;
  logic [7:0]        link_trk_q, link_trk_d;
  logic [7:0]        link_sec_q, link_sec_d;
  logic              first_q, first_d;
  logic [7:0]        low_q, low_d;
  logic [ADDR_W:0]   wp_q, wp_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic              use_file_q;
  logic [ADDR_W-1:0] reloc_q;

  logic [7:0]        map_trk, map_sec;
  map_t              map;
  logic [7:0]        hi;
  logic              last;
  logic [ADDR_W-1:0] la;

  // Lookup serves the begin command and the next link
  assign map_trk = (item_i.cmd == CMD_BEGIN) ? item_i.trk : link_trk_q;
  assign map_sec = (item_i.cmd == CMD_BEGIN) ? item_i.sec : link_sec_q;

  dsl_sector_map u_map (
    .trk_i (map_trk),
    .sec_i (map_sec),
    .map_o (map)
  );

  assign last = (link_trk_q == 8'd0);
  assign hi   = last ? link_sec_q : 8'hFF;
  assign la   = {item_i.data, low_q};

  // Work out the result and the next chain state
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    link_trk_d = link_trk_q;
    link_sec_d = link_sec_q;
    first_d    = first_q;
    low_d      = low_q;
    wp_d       = wp_q;
    start_d    = start_q;
    blk_d      = blk_q;
    res_o      = '0;

    if (item_i.cmd == CMD_BEGIN) begin
      first_d = 1'b1;
      blk_d   = '0;
      wp_d    = '0;
      start_d = '0;
      pos_d   = '0;
      if ((item_i.trk < 8'd1) || (item_i.trk > 8'(NUM_TRACKS))) begin
        res_o.ev = EV_DONE;
        phase_d  = PH_IDLE;
      end else if (map.ok) begin
        res_o.ev          = EV_READ;
        res_o.read_offset = map.offset;
        phase_d           = PH_RECV;
      end else begin
        res_o.ev = EV_ERR;
        phase_d  = PH_IDLE;
      end
    end else if (phase_q == PH_RECV) begin
      // Link bytes, load address on the first sector, then data up to the last used byte
      if (pos_q == 8'd0) begin
        link_trk_d = item_i.data;
      end else if (pos_q == 8'd1) begin
        link_sec_d = item_i.data;
      end else if (first_q && (pos_q == 8'd2)) begin
        low_d = item_i.data;
      end else if (first_q && (pos_q == 8'd3)) begin
        wp_d    = use_file_q ? {1'b0, la} : {1'b0, reloc_q};
        start_d = wp_d[ADDR_W-1:0];
      end else if ((pos_q <= hi) && !wp_q[ADDR_W]) begin
        res_o.wr_valid = 1'b1;
        res_o.wr_addr  = wp_q[ADDR_W-1:0];
        res_o.wr_data  = item_i.data;
        wp_d           = wp_q + 17'd1;
      end

      // Close the sector: error, done or next request
      if (pos_q == 8'hFF) begin
        first_d = 1'b0;
        if (first_q && (hi < 8'd3)) begin
          res_o.ev = EV_ERR;
          phase_d  = PH_IDLE;
        end else if (last || (link_trk_q > 8'(NUM_TRACKS)) ||
                     (({1'b0, blk_q} + 14'd1) >= 14'(MAX_BLOCKS))) begin
          res_o.ev         = EV_DONE;
          res_o.start_addr = start_q;
          res_o.end_addr   = wp_d[ADDR_W-1:0];
          phase_d          = PH_IDLE;
        end else begin
          blk_d = blk_q + 13'd1;
          if (map.ok) begin
            res_o.ev          = EV_READ;
            res_o.read_offset = map.offset;
            phase_d           = PH_RECV;
            pos_d             = '0;
          end else begin
            res_o.ev = EV_ERR;
            phase_d  = PH_IDLE;
          end
        end
      end else begin
        pos_d = pos_q + 8'd1;
      end
    end
  end

  // Advance chain state on each processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      pos_q      <= '0;
      link_trk_q <= '0;
      link_sec_q <= '0;
      first_q    <= 1'b1;
      low_q      <= '0;
      wp_q       <= '0;
      start_q    <= '0;
      blk_q      <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      link_trk_q <= link_trk_d;
      link_sec_q <= link_sec_d;
      first_q    <= first_d;
      low_q      <= low_d;
      wp_q       <= wp_d;
      start_q    <= start_d;
      blk_q      <= blk_d;
    end
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_file_q <= 1'b1;
      reloc_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_USE_FILE_ADDR: use_file_q <= cfg_data_i[0];
        CFG_RELOC_ADDR:    reloc_q    <= cfg_data_i;
        default:           use_file_q <= use_file_q;
      endcase
    end
  end

endmodule

/* test/disk_image_sector_chain_loader_test.sv */
// Self-checking testbench for the sector chain loader: queued chains, predicted results.
`timescale 1ns / 1ps

module disk_image_sector_chain_loader_test;
  import dsl_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned PHASE_ITEMS  = 265;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 40;

  // Kinds of chain the stimulus builds
  typedef enum int unsigned {
    CH_PLAIN,
    CH_TWO_BLOCKS,
    CH_SHORT_FIRST,
    CH_FAR_TRACK,
    CH_BAD_LINK,
    CH_CUT,
    CH_MEM_TOP,
    CH_KINDS
  } chain_kind_e;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic              command_i       = 1'b0;
  logic [7:0]        start_track_i   = '0;
  logic [7:0]        start_sector_i  = '0;
  logic [7:0]        data_byte_i     = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic              write_valid_o;
  logic [ADDR_W-1:0] write_address_o;
  logic [7:0]        write_data_o;
  logic [1:0]        event_res_o;
  logic [OFS_W-1:0]  read_offset_o;
  logic [ADDR_W-1:0] start_address_o;
  logic [ADDR_W-1:0] end_address_o;
  logic              cfg_we_i        = 1'b0;
  logic              cfg_index_i     = 1'b0;
  logic [ADDR_W-1:0] cfg_data_i      = '0;

  disk_image_sector_chain_loader dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .start_track_i   (start_track_i),
    .start_sector_i  (start_sector_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .write_valid_o   (write_valid_o),
    .write_address_o (write_address_o),
    .write_data_o    (write_data_o),
    .event_res_o     (event_res_o),
    .read_offset_o   (read_offset_o),
    .start_address_o (start_address_o),
    .end_address_o   (end_address_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  in_item_t    feed_q[$];
  res_t        outcome_q[$];
  in_item_t    feed_now;
  res_t        res_want;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned result_cnt     = 0;
  int unsigned cycle_cnt      = 0;
  int unsigned fed_cnt        = 0;
  int unsigned kind_seq       = 0;
  int unsigned hold_left      = 0;
  logic        hold_go        = 1'b0;

  // Predicted chain state, at its reset values
  phase_e          ch_phase    = PH_IDLE;
  logic [7:0]      ch_pos      = '0;
  logic [7:0]      ch_link_trk = '0;
  logic [7:0]      ch_link_sec = '0;
  logic            ch_first    = 1'b1;
  logic [7:0]      ch_low      = '0;
  logic [16:0]     ch_ptr      = '0;
  logic [15:0]     ch_start    = '0;
  logic [BLK_W-1:0] ch_blocks  = '0;
  logic            cfg_use_file = 1'b1;
  logic [15:0]     cfg_reloc    = '0;

  // Zoned layout: sectors per track, none off the disk
  function automatic int unsigned sectors_on(input int unsigned trk);
    if (trk < 1 || trk > NUM_TRACKS) return 0;
    if (trk <= 17) return 21;
    if (trk <= 24) return 19;
    if (trk <= 30) return 18;
    return 17;
  endfunction

  // Issue a read for a real sector, or flag an error
  function automatic void ask_sector(input logic [7:0] trk, input logic [7:0] sec,
                                     inout res_t r);
    int unsigned blocks = 0;
    if (sec < sectors_on(trk)) begin
      for (int unsigned t = 1; t < trk; t++) blocks += sectors_on(t);
      r.ev = EV_READ;
      r.read_offset = (blocks + sec) * 256;
      ch_phase = PH_RECV;
      ch_pos = '0;
    end else begin
      r.ev = EV_ERR;
      ch_phase = PH_IDLE;
    end
  endfunction

  function automatic void close_load(inout res_t r);
    r.ev = EV_DONE;
    r.start_addr = ch_start;
    r.end_addr = ch_ptr[15:0];
    ch_phase = PH_IDLE;
  endfunction

  // Advance the chain by one transfer and return the result it gives
  function automatic res_t loader_step(input in_item_t it);
    res_t       r;
    logic [7:0] pos;
    logic [7:0] hi;
    logic       was_first;
    r = '0;
    if (it.cmd == CMD_BEGIN) begin
      ch_first = 1'b1;
      ch_blocks = '0;
      ch_ptr = '0;
      ch_start = '0;
      ch_pos = '0;
      if (it.trk < 1 || it.trk > NUM_TRACKS) close_load(r);
      else ask_sector(it.trk, it.sec, r);
    end else if (ch_phase == PH_RECV) begin
      pos = ch_pos;
      hi = (ch_link_trk == 0) ? ch_link_sec : 8'hFF;
      if (pos == 0) begin
        ch_link_trk = it.data;
      end else if (pos == 1) begin
        ch_link_sec = it.data;
      end else if (ch_first && pos == 2) begin
        ch_low = it.data;
      end else if (ch_first && pos == 3) begin
        ch_ptr = cfg_use_file ? {1'b0, it.data, ch_low} : {1'b0, cfg_reloc};
        ch_start = ch_ptr[15:0];
      end else if (pos <= hi && !ch_ptr[16]) begin
        r.wr_valid = 1'b1;
        r.wr_addr = ch_ptr[15:0];
        r.wr_data = it.data;
        ch_ptr++;
      end
      // Decide the next step once the sector is complete
      if (pos == 8'hFF) begin
        was_first = ch_first;
        hi = (ch_link_trk == 0) ? ch_link_sec : 8'hFF;
        ch_first = 1'b0;
        if (was_first && hi < 3) begin
          r.ev = EV_ERR;
          ch_phase = PH_IDLE;
        end else if (ch_link_trk == 0 || ch_link_trk > NUM_TRACKS) begin
          close_load(r);
        end else if (ch_blocks + 1 >= MAX_BLOCKS) begin
          close_load(r);
        end else begin
          ch_blocks++;
          ask_sector(ch_link_trk, ch_link_sec, r);
        end
      end else begin
        ch_pos = pos + 8'd1;
      end
    end
    return r;
  endfunction

  function automatic void push_begin(input logic [7:0] trk, input logic [7:0] sec);
    in_item_t it;
    it.cmd = CMD_BEGIN;
    it.trk = trk;
    it.sec = sec;
    it.data = 8'($urandom);
    feed_q.push_back(it);
    fed_cnt++;
  endfunction

  function automatic void push_byte(input logic [7:0] data);
    in_item_t it;
    it.cmd = CMD_BYTE;
    it.trk = 8'($urandom);
    it.sec = 8'($urandom);
    it.data = data;
    feed_q.push_back(it);
    fed_cnt++;
  endfunction

  function automatic void pick_sector(output logic [7:0] trk, output logic [7:0] sec);
    trk = 8'($urandom_range(1, NUM_TRACKS));
    sec = 8'($urandom_range(0, sectors_on(trk) - 1));
  endfunction

  // Queue one sector: link, load address on the first block, then payload
  function automatic void push_sector(input logic [7:0] lt, input logic [7:0] ls,
                                      input logic first, input logic [15:0] load,
                                      input int unsigned count);
    for (int unsigned p = 0; p < count; p++) begin
      if (p == 0) push_byte(lt);
      else if (p == 1) push_byte(ls);
      else if (first && p == 2) push_byte(load[7:0]);
      else if (first && p == 3) push_byte(load[15:8]);
      else push_byte(8'($urandom));
    end
  endfunction

  task automatic gen_chain(input chain_kind_e kind);
    logic [7:0]  trk;
    logic [7:0]  sec;
    logic [7:0]  lt;
    logic [7:0]  ls;
    logic [15:0] load;
    int unsigned nsec;
    pick_sector(trk, sec);
    if ($urandom_range(0, 9) == 0) begin
      trk = 8'($urandom);
      sec = 8'($urandom);
    end
    push_begin(trk, sec);
    if (sec >= sectors_on(trk)) return;
    nsec = (kind == CH_TWO_BLOCKS) ? 2 : 1;
    load = (kind == CH_MEM_TOP) ? {8'hFF, 8'($urandom)} : 16'($urandom);
    for (int unsigned i = 0; i < nsec; i++) begin
      if (i + 1 < nsec) begin
        pick_sector(lt, ls);
      end else begin
        case (kind)
          CH_SHORT_FIRST: begin
            lt = 8'd0;
            ls = 8'($urandom_range(0, 2));
          end
          CH_FAR_TRACK: begin
            lt = 8'($urandom_range(NUM_TRACKS + 1, 255));
            ls = 8'($urandom);
          end
          CH_BAD_LINK: begin
            lt = 8'($urandom_range(1, NUM_TRACKS));
            ls = 8'($urandom_range(sectors_on(lt), 255));
          end
          default: begin
            lt = 8'd0;
            ls = (i == 0) ? 8'($urandom_range(3, 255)) : 8'($urandom);
          end
        endcase
      end
      push_sector(lt, ls, i == 0, load, (kind == CH_CUT) ? $urandom_range(1, 255) : 256);
    end
    // Stray bytes: ignored when idle, or feed a cut sector
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
    end
  endtask

  task automatic fill_chains();
    int unsigned n0;
    n0 = fed_cnt;
    while (fed_cnt - n0 < PHASE_ITEMS) begin
      gen_chain(chain_kind_e'(kind_seq % CH_KINDS));
      kind_seq++;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (feed_q.size() != 0 || in_valid_i || outcome_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ADDR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_USE_FILE_ADDR) cfg_use_file = value[0];
    else cfg_reloc = value;
  endtask

  // Drain, reconfigure and set the idling for the next stretch
  task automatic set_phase(input int unsigned send_pct, input int unsigned stall_pct,
                           input logic use_file, input logic [15:0] reloc);
    wait_drained();
    write_reg(CFG_USE_FILE_ADDR, {15'($urandom), use_file});
    write_reg(CFG_RELOC_ADDR, reloc);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("result %0d: %s is %0h, expected %0h", result_cnt, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("disk_image_sector_chain_loader_test: FAIL");
      $finish;
    end
  end

  // Drive input transfers; predict each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) outcome_q.push_back(loader_step(feed_now));
      if (!in_valid_i || in_ready_o) begin
        if (feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          feed_now = feed_q.pop_front();
          in_valid_i <= 1'b1;
          command_i <= feed_now.cmd;
          start_track_i <= feed_now.trk;
          start_sector_i <= feed_now.sec;
          data_byte_i <= feed_now.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long back-pressure stretch on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Take result transfers and compare against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing pending", 32'd0, 32'd0);
        end else begin
          res_want = outcome_q.pop_front();
          check_field("write_valid", write_valid_o, res_want.wr_valid);
          check_field("write_address", write_address_o, res_want.wr_addr);
          check_field("write_data", write_data_o, res_want.wr_data);
          check_field("event_res", event_res_o, res_want.ev);
          check_field("read_offset", read_offset_o, res_want.read_offset);
          check_field("start_address", start_address_o, res_want.start_addr);
          check_field("end_address", end_address_o, res_want.end_addr);
        end
        result_cnt++;
      end
      out_ready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full rate, file address; begins at the track and sector edges first
    set_phase(0, 0, 1'b1, 16'h0000);
    push_begin(8'd0, 8'd0);
    push_begin(8'd36, 8'd0);
    push_begin(8'd255, 8'd255);
    push_byte(8'hFF);
    push_begin(8'd1, 8'd21);
    push_byte(8'h00);
    push_begin(8'd1, 8'd0);
    push_begin(8'd17, 8'd20);
    push_begin(8'd18, 8'd19);
    push_begin(8'd24, 8'd18);
    push_begin(8'd25, 8'd18);
    push_begin(8'd30, 8'd17);
    push_begin(8'd31, 8'd17);
    push_begin(8'd35, 8'd16);
    push_begin(8'd35, 8'd17);
    push_begin(8'd1, 8'd255);
    fill_chains();
    // Stall the results while the feed is full so the input backs up
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;

    set_phase(50, 0, 1'b0, 16'hFFFF);
    fill_chains();
    set_phase(0, 50, 1'b0, 16'h0000);
    fill_chains();
    set_phase(23, 23, 1'b1, 16'($urandom));
    fill_chains();

    wait_drained();
    if (outcome_q.size() != 0) report_mismatch("results never arrived", outcome_q.size(), 0);
    if (mismatch_cnt == 0) begin
      $display("disk_image_sector_chain_loader_test: PASS");
    end else begin
      $display("disk_image_sector_chain_loader_test: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/dsl_pkg.sv
rtl/dsl_sector_map.sv
rtl/dsl_chain_core.sv
rtl/disk_image_sector_chain_loader.sv
test/disk_image_sector_chain_loader_test.sv
